// ----- rtl/core/sfas_pkg.sv -----
// ----------------------------------------------------------------------------
// Single float add/sub package
// Field masks and the per-stage payload types of the adder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sfas_pkg;

  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
  localparam logic [31:0] MAN_MASK  = 32'h007f_ffff;
  localparam logic [23:0] HIDDEN    = 24'h80_0000;

  // Leading zeros of a nibble.
  localparam logic [2:0] NIB_LZ [16] = '{
    3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  // Stage one payload: aligned mantissas and the bypass decision.
  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_val;
    logic        same_sign;
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] big_man;
    logic [23:0] small_man;
  } s1_t;

  // Stage two payload: raw sum or difference.
  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_val;
    logic        same_sign;
    logic        sign;
    logic [7:0]  exp;
    logic [24:0] man;
  } s2_t;

  // Stage three payload: leading-zero count ready for the final shift.
  typedef struct packed {
    logic        bypass;
    logic [31:0] bypass_val;
    logic        same_sign;
    logic        sign;
    logic [7:0]  exp;
    logic [24:0] man;
    logic [4:0]  lz;
  } s3_t;

endpackage

`default_nettype wire

// ----- rtl/core/single_float_add_sub_unit.sv -----
// ----------------------------------------------------------------------------
// Single float add/sub unit
// Truncating single-precision adder/subtractor in a four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage: drive in_operation, in_operand_a and in_operand_b and pulse start.
// A request is taken at every rising edge with start high and busy low; busy
// is tied low, so one request can be issued every cycle. Subtraction flips
// the sign of operand b, except that subtracting an all-zero b returns a.
// An operand with a zero exponent makes the other operand the result, and
// there is no rounding and no NaN or infinity handling.
// A request taken at a rising edge passes through the registers s1_r, s2_r,
// s3_r and res_r, and its result shows on out_sum_bits with out_valid high.
// Stage one unpacks and aligns, stage two adds or subtracts, stage three
// counts leading zeros, stage four normalizes and packs. Throughput is one
// result a cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// A synchronous reset clears all valid bits, so no stale result appears;
// payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module single_float_add_sub_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  output logic [31:0]      out_sum_bits
);
  import sfas_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  s3_t         s3_r, s3_nxt;
  logic [31:0] res_r, res_nxt;
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stage one: sign flip, bypass cases, exponent compare and alignment.
  always_comb begin
    logic [31:0] a, b;
    logic [7:0]  ea, eb, d;
    logic [23:0] ma, mb;
    logic        a_big;
    a  = in_operand_a;
    b  = in_operand_b ^ (in_operation ? SIGN_MASK : 32'h0);
    ea = a[30:23];
    eb = b[30:23];
    ma = HIDDEN | {1'b0, a[22:0]};
    mb = HIDDEN | {1'b0, b[22:0]};
    s1_nxt = '0;
    if (in_operation && in_operand_b == 32'h0) begin
      s1_nxt.bypass = 1'b1; s1_nxt.bypass_val = a;
    end else if (ea == 8'd0) begin
      s1_nxt.bypass = 1'b1; s1_nxt.bypass_val = b;
    end else if (eb == 8'd0) begin
      s1_nxt.bypass = 1'b1; s1_nxt.bypass_val = a;
    end
    s1_nxt.same_sign = (a[31] == b[31]);
    // The larger magnitude leads; on equal exponents the mantissas decide.
    a_big = (ea > eb) || (ea == eb && ma > mb);
    d = (ea > eb) ? (ea - eb) : (eb - ea);
    s1_nxt.exp  = (ea > eb) ? ea : eb;
    s1_nxt.sign = s1_nxt.same_sign ? a[31] : (a_big ? a[31] : b[31]);
    s1_nxt.big_man = a_big ? ma : mb;
    s1_nxt.small_man = (d >= 8'd24) ? 24'd0 :
                       ((a_big ? mb : ma) >> d[4:0]);
  end

  // Stage two: add or subtract mantissas.
  always_comb begin
    s2_nxt.bypass     = s1_r.bypass;
    s2_nxt.bypass_val = s1_r.bypass_val;
    s2_nxt.same_sign  = s1_r.same_sign;
    s2_nxt.sign       = s1_r.sign;
    s2_nxt.exp        = s1_r.exp;
    s2_nxt.man = s1_r.same_sign ? ({1'b0, s1_r.big_man} + {1'b0, s1_r.small_man})
                                : ({1'b0, s1_r.big_man} - {1'b0, s1_r.small_man});
  end

  // Stage three: leading-zero count over the 24-bit difference, by nibbles.
  always_comb begin
    logic [4:0] cnt;
    logic       done;
    cnt  = 5'd0;
    done = 1'b0;
    for (int i = 5; i >= 0; i--) begin
      if (!done) begin
        cnt = cnt + 5'(NIB_LZ[s2_r.man[i*4 +: 4]]);
        if (s2_r.man[i*4 +: 4] != 4'd0) done = 1'b1;
      end
    end
    s3_nxt.bypass     = s2_r.bypass;
    s3_nxt.bypass_val = s2_r.bypass_val;
    s3_nxt.same_sign  = s2_r.same_sign;
    s3_nxt.sign       = s2_r.sign;
    s3_nxt.exp        = s2_r.exp;
    s3_nxt.man        = s2_r.man;
    s3_nxt.lz         = cnt;
  end

  // Stage four: normalize, saturate or flush, and pack.
  always_comb begin
    logic [8:0]  ec;
    logic [23:0] mc;
    ec = {1'b0, s3_r.exp};
    mc = s3_r.man[23:0];
    if (s3_r.bypass) begin
      res_nxt = s3_r.bypass_val;
    end else if (s3_r.same_sign) begin
      if (s3_r.man[24]) begin
        mc = s3_r.man[24:1];
        ec = ec + 9'd1;
      end
      if (ec >= 9'd255) res_nxt = {s3_r.sign, 31'h7f80_0000};
      else              res_nxt = {s3_r.sign, ec[7:0], mc[22:0]};
    end else if (s3_r.man[23:0] == 24'd0) begin
      res_nxt = 32'h0;
    end else if (ec <= {4'd0, s3_r.lz}) begin
      res_nxt = (s3_r.lz == 5'd0) ? {s3_r.sign, ec[7:0], mc[22:0]} : 32'h0;
    end else begin
      mc = mc << s3_r.lz;
      ec = ec - {4'd0, s3_r.lz};
      res_nxt = {s3_r.sign, ec[7:0], mc[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= accept; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    res_r <= res_nxt;
  end

  assign out_valid    = v4_r;
  assign out_sum_bits = res_r;

`ifndef NO_ASSERTIONS
  // Every request is followed by a result with out_valid high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid) else $error("result missing after request");
  // No result appears without an earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4)) else $error("unrequested result");
  // A nonzero nonbypass difference has a one at the bit the leading-zero count points to.
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !s3_r.bypass && !s3_r.same_sign && s3_r.man[23:0] != 24'd0)
      |-> s3_r.man[5'd23 - s3_r.lz]) else $error("bad leading-zero count");
`endif

endmodule

`default_nettype wire
